// ===== hw/rtl/mpsol_pkg.sv =====
package mpsol_pkg;

	localparam int unsigned RUN_DEPTH    = 64;
	localparam int unsigned CHUNK_DEPTH  = 1024;
	localparam int unsigned SAMPLE_DEPTH = 4096;

	localparam int unsigned RUN_AW    = $clog2(RUN_DEPTH);
	localparam int unsigned CHUNK_AW  = $clog2(CHUNK_DEPTH);
	localparam int unsigned SAMPLE_AW = $clog2(SAMPLE_DEPTH);

	localparam int unsigned DIV_STEPS = SAMPLE_AW;
	localparam int unsigned DIV_CW    = $clog2(DIV_STEPS + 1);

	localparam logic [31:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_LOAD_RUN    = 2'd0,
		CMD_LOAD_CHUNK  = 2'd1,
		CMD_LOAD_SIZE   = 2'd2,
		CMD_QUERY       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_RUN_USED   = 2'd0,
		REG_CHUNK_USED = 2'd1,
		REG_SIZE_USED  = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SAMPLE = 2'd1,
		ST_NO_CHUNK  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RUN_RD,
		S_RUN_MUL,
		S_RUN_CMP,
		S_DIV,
		S_CHK,
		S_SUM_RD,
		S_SUM_ACC,
		S_OFF_RD,
		S_OFF_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

// ===== hw/rtl/mpsol_div.sv =====
module mpsol_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [mpsol_pkg::SAMPLE_AW-1:0]     dividend,
	input  logic [31:0]                         divisor,
	output mpsol_pkg::div_ctl_t                 ctl,
	output logic [mpsol_pkg::SAMPLE_AW-1:0]     quot,
	output logic [mpsol_pkg::SAMPLE_AW-1:0]     rem
);

	logic [mpsol_pkg::DIV_CW-1:0]    cnt_q;
	logic                            run_q;
	logic                            done_q;
	logic [mpsol_pkg::SAMPLE_AW-1:0] num_q;
	logic [mpsol_pkg::SAMPLE_AW-1:0] quot_q;
	logic [mpsol_pkg::SAMPLE_AW:0]   rem_q;
	logic [31:0]                     den_q;
	logic [mpsol_pkg::SAMPLE_AW:0]   shifted;
	logic                            ge;

	// remainder stays below divisor and below the dividend range
	assign shifted = {rem_q[mpsol_pkg::SAMPLE_AW-1:0], num_q[mpsol_pkg::SAMPLE_AW-1]};
	assign ge      = {{(32-mpsol_pkg::SAMPLE_AW-1){1'b0}}, shifted} >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= mpsol_pkg::DIV_CW'(mpsol_pkg::DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mpsol_pkg::DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			num_q  <= {num_q[mpsol_pkg::SAMPLE_AW-2:0], 1'b0};
			rem_q  <= ge ? (shifted - den_q[mpsol_pkg::SAMPLE_AW:0]) : shifted;
			quot_q <= {quot_q[mpsol_pkg::SAMPLE_AW-2:0], ge};
		end
	end

	assign ctl.start = start;
	assign ctl.done  = done_q;
	assign quot      = quot_q;
	assign rem       = rem_q[mpsol_pkg::SAMPLE_AW-1:0];

endmodule

// ===== hw/rtl/mp4_sample_offset_lookup_top.sv =====
// Channel  | Ports                                        | Handshake
// request  | cmd, entry_index, run_*, chunk_file_offset,  | start & !busy
//          | sample_bytes, query_sample                   |
// result   | byte_position, description_index,            | done, one cycle
//          | lookup_status                                |
// config   | cfg_we, cfg_index, cfg_data                  | cfg_we
// Loads are written when accepted; the block stays idle. A query rejected early
// is answered from idle; else it walks the runs, then divides (one quotient bit
// a cycle), sums one size read per earlier sample in the chunk, reads the offset.
// Reset clears counts and sequencer; table contents are undefined until loaded.
// The receiver cannot stall: each result shows for one cycle with done.
module mp4_sample_offset_lookup_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [11:0] entry_index,
	input  logic [31:0] run_first_chunk,
	input  logic [31:0] run_samples_per_chunk,
	input  logic [31:0] run_description,
	input  logic [31:0] chunk_file_offset,
	input  logic [31:0] sample_bytes,
	input  logic [11:0] query_sample,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output logic        done,
	output logic [32:0] byte_position,
	output logic [31:0] description_index,
	output logic [1:0]  lookup_status
);

	localparam int unsigned RAW = mpsol_pkg::RUN_AW;
	localparam int unsigned CAW = mpsol_pkg::CHUNK_AW;
	localparam int unsigned SAW = mpsol_pkg::SAMPLE_AW;

	mpsol_pkg::state_t state_q, state_d;

	logic [6:0]  run_used_q;
	logic [10:0] chunk_used_q;
	logic [12:0] size_used_q;

	logic [31:0] run_first_mem [mpsol_pkg::RUN_DEPTH];
	logic [31:0] run_count_mem [mpsol_pkg::RUN_DEPTH];
	logic [31:0] run_desc_mem  [mpsol_pkg::RUN_DEPTH];
	logic [31:0] chunk_mem     [mpsol_pkg::CHUNK_DEPTH];
	logic [31:0] size_mem      [mpsol_pkg::SAMPLE_DEPTH];

	logic [31:0] first_rd_q, next_rd_q, spc_rd_q, desc_rd_q, size_rd_q, off_rd_q;

	logic [SAW-1:0] sample_q;
	logic [6:0]     run_q;
	logic [SAW-1:0] done_cnt_q;
	logic           next_ok_q;
	logic [63:0]    span_q;
	logic [31:0]    first_q, spc_q, desc_q;
	logic [32:0]    chunk_q;
	logic [SAW-1:0] k_q;
	logic [SAW-1:0] cnt_q;
	logic [43:0]    sum_q;

	logic           accept;
	logic           is_query;
	logic           early_fail;
	logic [31:0]    next_val;
	logic [31:0]    chunks;
	logic [SAW-1:0] rel;
	logic           hit;
	logic           last_run;
	logic [32:0]    chunk_calc;
	logic           chunk_bad;
	logic [RAW-1:0] run_addr, run_addr2;

	mpsol_pkg::div_ctl_t div_ctl;
	logic [SAW-1:0]      div_quot, div_rem;

	assign busy       = (state_q != mpsol_pkg::S_IDLE);
	assign accept     = start && !busy;
	assign is_query   = (cmd == mpsol_pkg::CMD_QUERY);
	assign early_fail = ({1'b0, query_sample} >= size_used_q) || (run_used_q == '0);

	assign run_addr   = run_q[RAW-1:0];
	assign run_addr2  = run_addr + 1'b1;
	assign next_val   = next_ok_q ? next_rd_q : mpsol_pkg::WORD_ALL_ONES;
	assign chunks     = (next_val > first_rd_q) ? (next_val - first_rd_q) : '0;
	assign rel        = sample_q - done_cnt_q;
	assign hit        = {{(64-SAW){1'b0}}, rel} < span_q;
	assign last_run   = (run_q + 7'd1) >= run_used_q;
	assign chunk_calc = {1'b0, first_q} + {{(33-SAW){1'b0}}, div_quot};
	assign chunk_bad  = (chunk_calc == '0) || (chunk_calc > {22'd0, chunk_used_q});

	mpsol_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == mpsol_pkg::S_RUN_CMP && hit),
		.dividend (rel),
		.divisor  (spc_q),
		.ctl      (div_ctl),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_used_q   <= '0;
			chunk_used_q <= '0;
			size_used_q  <= '0;
		end else if (cfg_we) begin
			unique case (mpsol_pkg::reg_idx_t'(cfg_index))
				mpsol_pkg::REG_RUN_USED: begin
					run_used_q <= (cfg_data[6:0] > 7'(mpsol_pkg::RUN_DEPTH))
						? 7'(mpsol_pkg::RUN_DEPTH) : cfg_data[6:0];
				end
				mpsol_pkg::REG_CHUNK_USED: begin
					chunk_used_q <= (cfg_data[10:0] > 11'(mpsol_pkg::CHUNK_DEPTH))
						? 11'(mpsol_pkg::CHUNK_DEPTH) : cfg_data[10:0];
				end
				mpsol_pkg::REG_SIZE_USED: begin
					size_used_q <= (cfg_data > 13'(mpsol_pkg::SAMPLE_DEPTH))
						? 13'(mpsol_pkg::SAMPLE_DEPTH) : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// tables
	always_ff @(posedge clk) begin
		if (accept && cmd == mpsol_pkg::CMD_LOAD_RUN && entry_index[11:RAW] == '0) begin
			run_first_mem[entry_index[RAW-1:0]] <= run_first_chunk;
			run_count_mem[entry_index[RAW-1:0]] <= run_samples_per_chunk;
			run_desc_mem[entry_index[RAW-1:0]]  <= run_description;
		end
		first_rd_q <= run_first_mem[run_addr];
		next_rd_q  <= run_first_mem[run_addr2];
		spc_rd_q   <= run_count_mem[run_addr];
		desc_rd_q  <= run_desc_mem[run_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == mpsol_pkg::CMD_LOAD_CHUNK && entry_index[11:CAW] == '0) begin
			chunk_mem[entry_index[CAW-1:0]] <= chunk_file_offset;
		end
		off_rd_q <= chunk_mem[chunk_q[CAW-1:0] - 1'b1];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == mpsol_pkg::CMD_LOAD_SIZE) begin
			size_mem[entry_index[SAW-1:0]] <= sample_bytes;
		end
		size_rd_q <= size_mem[k_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpsol_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpsol_pkg::S_IDLE: begin
				if (accept && is_query && !early_fail) state_d = mpsol_pkg::S_RUN_RD;
			end
			mpsol_pkg::S_RUN_RD:  state_d = mpsol_pkg::S_RUN_MUL;
			mpsol_pkg::S_RUN_MUL: state_d = mpsol_pkg::S_RUN_CMP;
			mpsol_pkg::S_RUN_CMP: begin
				if (hit)           state_d = mpsol_pkg::S_DIV;
				else if (last_run) state_d = mpsol_pkg::S_IDLE;
				else               state_d = mpsol_pkg::S_RUN_RD;
			end
			mpsol_pkg::S_DIV: begin
				if (div_ctl.done) state_d = mpsol_pkg::S_CHK;
			end
			mpsol_pkg::S_CHK: begin
				if (chunk_bad)           state_d = mpsol_pkg::S_IDLE;
				else if (div_rem != '0)  state_d = mpsol_pkg::S_SUM_RD;
				else                     state_d = mpsol_pkg::S_OFF_RD;
			end
			mpsol_pkg::S_SUM_RD:  state_d = mpsol_pkg::S_SUM_ACC;
			mpsol_pkg::S_SUM_ACC: begin
				state_d = (cnt_q != '0) ? mpsol_pkg::S_SUM_RD : mpsol_pkg::S_OFF_RD;
			end
			mpsol_pkg::S_OFF_RD:  state_d = mpsol_pkg::S_OFF_OUT;
			mpsol_pkg::S_OFF_OUT: state_d = mpsol_pkg::S_IDLE;
			default:              state_d = mpsol_pkg::S_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mpsol_pkg::S_IDLE: begin
				sample_q   <= query_sample;
				run_q      <= '0;
				done_cnt_q <= '0;
			end
			mpsol_pkg::S_RUN_RD: begin
				next_ok_q <= (run_q + 7'd1) < run_used_q;
			end
			mpsol_pkg::S_RUN_MUL: begin
				span_q  <= chunks * spc_rd_q;
				first_q <= first_rd_q;
				spc_q   <= spc_rd_q;
				desc_q  <= desc_rd_q;
			end
			mpsol_pkg::S_RUN_CMP: begin
				if (!hit) begin
					done_cnt_q <= done_cnt_q + span_q[SAW-1:0];
					run_q      <= run_q + 7'd1;
				end
			end
			mpsol_pkg::S_CHK: begin
				chunk_q <= chunk_calc;
				k_q     <= sample_q - div_rem;
				cnt_q   <= div_rem;
				sum_q   <= '0;
			end
			mpsol_pkg::S_SUM_RD: begin
				k_q   <= k_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
			mpsol_pkg::S_SUM_ACC: begin
				sum_q <= sum_q + {12'd0, size_rd_q};
			end
			default: begin
			end
		endcase
	end

	// result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (accept && is_query && early_fail)
				|| (state_q == mpsol_pkg::S_RUN_CMP && !hit && last_run)
				|| (state_q == mpsol_pkg::S_CHK && chunk_bad)
				|| (state_q == mpsol_pkg::S_OFF_OUT);
		end
	end

	always_ff @(posedge clk) begin
		byte_position     <= '0;
		description_index <= '0;
		lookup_status     <= mpsol_pkg::ST_NO_SAMPLE;
		if (state_q == mpsol_pkg::S_CHK) begin
			description_index <= desc_q;
			lookup_status     <= mpsol_pkg::ST_NO_CHUNK;
		end else if (state_q == mpsol_pkg::S_OFF_OUT) begin
			description_index <= desc_q;
			if (sum_q > {12'd0, mpsol_pkg::WORD_ALL_ONES}) begin
				lookup_status <= mpsol_pkg::ST_OVERFLOW;
			end else begin
				lookup_status <= mpsol_pkg::ST_OK;
				byte_position <= {1'b0, off_rd_q} + {1'b0, sum_q[31:0]};
			end
		end
	end

endmodule
